@@ hdl/vba_pkg.sv @@
`timescale 1ns / 1ps

package vba_pkg;

  // Reset value of the search start register and the highest reportable base.
  localparam logic [7:0] SEARCH_START_RESET = 8'd32;
  localparam logic [7:0] BASE_LIMIT         = 8'd255;

  // Microcode step addresses.
  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_FIX_SEL   = 4'd2;
  localparam logic [3:0] ST_FIX_ZERO  = 4'd3;
  localparam logic [3:0] ST_FIX_BOUND = 4'd4;
  localparam logic [3:0] ST_FIX_SCAN  = 4'd5;
  localparam logic [3:0] ST_FIX_FAIL  = 4'd6;
  localparam logic [3:0] ST_SRCH_ZERO = 4'd7;
  localparam logic [3:0] ST_SRCH_INIT = 4'd8;
  localparam logic [3:0] ST_SRCH_SCAN = 4'd9;
  localparam logic [3:0] ST_MARK_INIT = 4'd10;
  localparam logic [3:0] ST_MARK_RUN  = 4'd11;
  localparam logic [3:0] ST_GRANT     = 4'd12;
  localparam logic [3:0] ST_FAIL      = 4'd13;
  localparam logic [3:0] ST_GRANT_SS  = 4'd14;

  // Jump condition codes.
  localparam logic [3:0] C_NEVER     = 4'd0;
  localparam logic [3:0] C_ALWAYS    = 4'd1;
  localparam logic [3:0] C_NO_REQ    = 4'd2;
  localparam logic [3:0] C_NO_HINT   = 4'd3;
  localparam logic [3:0] C_CNT_ZERO  = 4'd4;
  localparam logic [3:0] C_OVER      = 4'd5;
  localparam logic [3:0] C_TAKEN     = 4'd6;
  localparam logic [3:0] C_AT_END    = 4'd7;
  localparam logic [3:0] C_FIXED     = 4'd8;
  localparam logic [3:0] C_SCAN_STOP = 4'd9;
  localparam logic [3:0] C_FOUND     = 4'd10;
  localparam logic [3:0] C_NO_MARK   = 4'd11;
  localparam logic [3:0] C_OUT_BUSY  = 4'd12;
  localparam logic [3:0] C_CLR_END   = 4'd13;

  // Datapath operation codes.
  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_NEXT      = 4'd2;
  localparam logic [3:0] OP_SRCH_INIT = 4'd3;
  localparam logic [3:0] OP_SCAN      = 4'd4;
  localparam logic [3:0] OP_MARK_INIT = 4'd5;
  localparam logic [3:0] OP_MARK      = 4'd6;
  localparam logic [3:0] OP_CLEAR     = 4'd7;
  localparam logic [3:0] OP_BASE_SS   = 4'd8;
  localparam logic [3:0] OP_EMIT_OK   = 4'd9;
  localparam logic [3:0] OP_EMIT_FAIL = 4'd10;

  // One control word: two prioritized conditional jumps, then hold or advance.
  typedef struct packed {
    logic [3:0] cond_a;
    logic [3:0] tgt_a;
    logic [3:0] cond_b;
    logic [3:0] tgt_b;
    logic       hold;
    logic [3:0] op;
  } ctrl_t;

  // Status flags the datapath hands back to the sequencer.
  typedef struct packed {
    logic no_req;
    logic no_hint;
    logic cnt_zero;
    logic over;
    logic taken;
    logic at_end;
    logic fixed;
    logic scan_stop;
    logic found;
    logic no_mark;
    logic out_busy;
    logic clr_end;
  } flags_t;

  function automatic ctrl_t mk(input logic [3:0] ca, input logic [3:0] ta,
                               input logic [3:0] cb, input logic [3:0] tb,
                               input logic h, input logic [3:0] o);
    ctrl_t w;
    w.cond_a = ca;
    w.tgt_a  = ta;
    w.cond_b = cb;
    w.tgt_b  = tb;
    w.hold   = h;
    w.op     = o;
    return w;
  endfunction

  // The control program.
  function automatic ctrl_t ucode(input logic [3:0] step);
    ctrl_t w;
    case (step)
      ST_CLEAR:     w = mk(C_CLR_END, ST_IDLE, C_NEVER, ST_IDLE, 1'b1, OP_CLEAR);
      ST_IDLE:      w = mk(C_NO_REQ, ST_IDLE, C_NEVER, ST_IDLE, 1'b0, OP_LOAD);
      ST_FIX_SEL:   w = mk(C_NO_HINT, ST_SRCH_ZERO, C_NEVER, ST_IDLE, 1'b0, OP_NOP);
      ST_FIX_ZERO:  w = mk(C_CNT_ZERO, ST_GRANT, C_NEVER, ST_IDLE, 1'b0, OP_NOP);
      ST_FIX_BOUND: w = mk(C_OVER, ST_FIX_FAIL, C_NEVER, ST_IDLE, 1'b0, OP_NOP);
      ST_FIX_SCAN:  w = mk(C_TAKEN, ST_FIX_FAIL, C_AT_END, ST_MARK_INIT, 1'b1, OP_NEXT);
      ST_FIX_FAIL:  w = mk(C_FIXED, ST_FAIL, C_NEVER, ST_IDLE, 1'b0, OP_NOP);
      ST_SRCH_ZERO: w = mk(C_CNT_ZERO, ST_GRANT_SS, C_NEVER, ST_IDLE, 1'b0, OP_NOP);
      ST_SRCH_INIT: w = mk(C_NEVER, ST_IDLE, C_NEVER, ST_IDLE, 1'b0, OP_SRCH_INIT);
      ST_SRCH_SCAN: w = mk(C_SCAN_STOP, ST_FAIL, C_FOUND, ST_MARK_INIT, 1'b1, OP_SCAN);
      ST_MARK_INIT: w = mk(C_NO_MARK, ST_GRANT, C_NEVER, ST_IDLE, 1'b0, OP_MARK_INIT);
      ST_MARK_RUN:  w = mk(C_AT_END, ST_GRANT, C_NEVER, ST_IDLE, 1'b1, OP_MARK);
      ST_GRANT:     w = mk(C_OUT_BUSY, ST_GRANT, C_ALWAYS, ST_IDLE, 1'b0, OP_EMIT_OK);
      ST_FAIL:      w = mk(C_OUT_BUSY, ST_FAIL, C_ALWAYS, ST_IDLE, 1'b0, OP_EMIT_FAIL);
      ST_GRANT_SS:  w = mk(C_ALWAYS, ST_GRANT, C_NEVER, ST_IDLE, 1'b0, OP_BASE_SS);
      default:      w = mk(C_ALWAYS, ST_IDLE, C_NEVER, ST_IDLE, 1'b0, OP_NOP);
    endcase
    return w;
  endfunction

endpackage

@@ hdl/vba_seq.sv @@
`timescale 1ns / 1ps

module vba_seq import vba_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  logic [3:0] step_r, step_nxt;
  logic       jump_a, jump_b;

  // Evaluate one condition code against the datapath flags.
  function automatic logic test(input logic [3:0] c, input flags_t f);
    logic r;
    case (c)
      C_NEVER:     r = 1'b0;
      C_ALWAYS:    r = 1'b1;
      C_NO_REQ:    r = f.no_req;
      C_NO_HINT:   r = f.no_hint;
      C_CNT_ZERO:  r = f.cnt_zero;
      C_OVER:      r = f.over;
      C_TAKEN:     r = f.taken;
      C_AT_END:    r = f.at_end;
      C_FIXED:     r = f.fixed;
      C_SCAN_STOP: r = f.scan_stop;
      C_FOUND:     r = f.found;
      C_NO_MARK:   r = f.no_mark;
      C_OUT_BUSY:  r = f.out_busy;
      C_CLR_END:   r = f.clr_end;
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  // Control word for the current step comes straight from the program table.
  assign ctrl   = ucode(step_r);
  assign jump_a = test(ctrl.cond_a, flags);
  assign jump_b = test(ctrl.cond_b, flags);

  // Next step: first jump wins, then second, then hold or advance.
  always_comb begin
    if (jump_a) begin
      step_nxt = ctrl.tgt_a;
    end else if (jump_b) begin
      step_nxt = ctrl.tgt_b;
    end else if (ctrl.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ hdl/vba_dp.sv @@
`timescale 1ns / 1ps

module vba_dp import vba_pkg::*; #(
  parameter int NUM_VECTORS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_t      ctrl,
  output flags_t     flags,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [8:0] in_count,
  input  logic [7:0] in_base_hint,
  input  logic       in_fixed_mode,
  input  logic       in_exclusive,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic       out_status,
  output logic [7:0] out_granted_base,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int AW = $clog2(NUM_VECTORS);
  localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;
  localparam logic [CW-1:0] NV = CW'(NUM_VECTORS);

  logic [8:0]    count_r, count_nxt;
  logic [7:0]    hint_r, hint_nxt;
  logic          fixed_r, fixed_nxt;
  logic          excl_r, excl_nxt;
  logic [7:0]    base_r, base_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] run_off_r, run_off_nxt;
  logic [8:0]    run_len_r, run_len_nxt;
  logic [7:0]    ss_r;
  logic          out_valid_r, out_valid_nxt;
  logic          out_status_r, out_status_nxt;
  logic [7:0]    out_base_r, out_base_nxt;
  logic          mem_we;
  logic          mem_wd;
  logic          rd_bit_r;
  logic          taken_map [NUM_VECTORS];
  logic [CW-1:0] hint_ext, base_ext, count_ext, ss_ext, run_end;
  logic          out_busy;
  logic          in_xfer;

  assign hint_ext  = {{(CW-8){1'b0}}, hint_r};
  assign base_ext  = {{(CW-8){1'b0}}, base_r};
  assign count_ext = {{(CW-9){1'b0}}, count_r};
  assign ss_ext    = {{(CW-8){1'b0}}, ss_r};
  assign run_end   = base_ext + count_ext - CW'(1);

  assign in_tready = (ctrl.op == OP_LOAD);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;
  assign cfg_ready = 1'b1;

  // Flags for the sequencer's jump conditions.
  always_comb begin
    flags.no_req    = !in_tvalid;
    flags.no_hint   = !fixed_r && (hint_r == 8'd0);
    flags.cnt_zero  = (count_r == 9'd0);
    flags.over      = (hint_ext + count_ext) > NV;
    flags.taken     = rd_bit_r;
    flags.at_end    = (i_r == run_end);
    flags.fixed     = fixed_r;
    flags.scan_stop = (i_r >= NV) || (run_off_r > CW'(BASE_LIMIT));
    flags.found     = !rd_bit_r && (({1'b0, run_len_r} + 10'd1) >= {1'b0, count_r});
    flags.no_mark   = !excl_r || (count_r == 9'd0);
    flags.out_busy  = out_busy;
    flags.clr_end   = (i_r == NV - CW'(1));
  end

  // Datapath actions selected by the control word.
  always_comb begin
    count_nxt      = count_r;
    hint_nxt       = hint_r;
    fixed_nxt      = fixed_r;
    excl_nxt       = excl_r;
    base_nxt       = base_r;
    i_nxt          = i_r;
    run_off_nxt    = run_off_r;
    run_len_nxt    = run_len_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_base_nxt   = out_base_r;
    mem_we         = 1'b0;
    mem_wd         = 1'b0;
    case (ctrl.op)
      OP_LOAD: begin
        if (in_xfer) begin
          count_nxt = in_count;
          hint_nxt  = in_base_hint;
          fixed_nxt = in_fixed_mode;
          excl_nxt  = in_exclusive;
          base_nxt  = in_base_hint;
          i_nxt     = {{(CW-8){1'b0}}, in_base_hint};
        end
      end
      OP_NEXT: begin
        i_nxt = i_r + CW'(1);
      end
      OP_SRCH_INIT: begin
        i_nxt       = ss_ext;
        run_off_nxt = ss_ext;
        run_len_nxt = 9'd0;
      end
      OP_SCAN: begin
        i_nxt = i_r + CW'(1);
        if (rd_bit_r) begin
          run_len_nxt = 9'd0;
          run_off_nxt = i_r + CW'(1);
        end else begin
          run_len_nxt = run_len_r + 9'd1;
          base_nxt    = run_off_r[7:0];
        end
      end
      OP_MARK_INIT: begin
        i_nxt = base_ext;
      end
      OP_MARK: begin
        i_nxt  = i_r + CW'(1);
        mem_we = (i_r < NV);
        mem_wd = 1'b1;
      end
      OP_CLEAR: begin
        i_nxt  = i_r + CW'(1);
        mem_we = 1'b1;
        mem_wd = 1'b0;
      end
      OP_BASE_SS: begin
        base_nxt = ss_r;
      end
      OP_EMIT_OK: begin
        if (!out_busy) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          out_base_nxt   = base_r;
        end
      end
      OP_EMIT_FAIL: begin
        if (!out_busy) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b1;
          out_base_nxt   = hint_r;
        end
      end
      default: begin
        i_nxt = i_r;
      end
    endcase
  end

  // Control registers and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      out_valid_r <= 1'b0;
      ss_r        <= SEARCH_START_RESET;
    end else begin
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        ss_r <= cfg_data;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    count_r      <= count_nxt;
    hint_r       <= hint_nxt;
    fixed_r      <= fixed_nxt;
    excl_r       <= excl_nxt;
    base_r       <= base_nxt;
    run_off_r    <= run_off_nxt;
    run_len_r    <= run_len_nxt;
    out_status_r <= out_status_nxt;
    out_base_r   <= out_base_nxt;
  end

  // Taken map: the read port follows the next index, so rd_bit_r holds the bit at i_r.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      taken_map[i_r[AW-1:0]] <= mem_wd;
    end
    rd_bit_r <= taken_map[i_nxt[AW-1:0]];
  end

  assign out_tvalid       = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_base = out_base_r;

endmodule

@@ hdl/vector_block_allocator_unit.sv @@
`timescale 1ns / 1ps

// Channel | Dir | Handshake               | Payload
// in_     | in  | in_tvalid / in_tready   | tdata: count, base_hint; tuser: fixed_mode, exclusive
// out_    | out | out_tvalid / out_tready | tdata: granted_base; tuser: status
// cfg_    | in  | cfg_valid / cfg_ready   | cfg_data: search_start
//
// One request at a time. A request runs through its control steps, plus a check of each vector
// at base_hint (up to count), plus each vector walked by the first-fit scan from search_start
// upward, plus, for an exclusive grant, marking the count vectors of the run.
// The map has one read and one write port, so the steps visit the vectors one at a time.
// After reset all NUM_VECTORS entries of the map are cleared, with in_tready low meanwhile.
// A held result stalls the sequencer in its final step; cfg_ready is always high.

module vector_block_allocator_unit import vba_pkg::*; #(
  parameter int NUM_VECTORS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [8:0] count, [16:9] base_hint, [23:17] zero
  input  logic [1:0]  in_tuser,   // [0] fixed_mode, [1] exclusive
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] granted_base
  output logic        out_tuser,  // [0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  ctrl_t  ctrl;
  flags_t flags;

  // Program sequencer.
  vba_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Map, scan registers and result register.
  vba_dp #(
    .NUM_VECTORS (NUM_VECTORS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .flags            (flags),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_count         (in_tdata[8:0]),
    .in_base_hint     (in_tdata[16:9]),
    .in_fixed_mode    (in_tuser[0]),
    .in_exclusive     (in_tuser[1]),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_status       (out_tuser),
    .out_granted_base (out_tdata),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // After a request transfer the block is not ready in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while a request is in progress");

  // The map clearing pass keeps requests out right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request port open during map clearing");

  // A new result only appears while a request is being worked on.
  a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result produced while idle");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb import vba_pkg::*; ();

  localparam int NUM_VECTORS = 256;

  // Result status codes.
  localparam logic STATUS_GRANTED = 1'b0;
  localparam logic STATUS_NO_RUN  = 1'b1;

  typedef struct packed {
    logic [8:0] count;
    logic [7:0] base_hint;
    logic       fixed_mode;
    logic       exclusive;
  } alloc_req_t;

  typedef struct packed {
    logic       status;
    logic [7:0] granted_base;
  } alloc_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;    // [8:0] count, [16:9] base_hint, [23:17] zero
  logic [1:0]  in_tuser = '0;    // [0] fixed_mode, [1] exclusive
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // [7:0] granted_base
  logic        out_tuser;        // [0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  // Predictor state: one taken mark per vector and the search start register.
  logic [NUM_VECTORS-1:0] model_taken;
  logic [7:0]             model_search_start;

  alloc_res_t expected_allocs[$];
  int         mismatch_count = 0;

  // Traffic shaping shared by the sender, the receiver and the tests.
  bit steady = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int rx_roll;

  vector_block_allocator_unit #(.NUM_VECTORS(NUM_VECTORS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Works out the result of one request and applies its marks to the map.
  function automatic alloc_res_t allocate_vectors(input alloc_req_t req);
    alloc_res_t  res;
    int unsigned cnt;
    int unsigned hint;
    int unsigned base;
    int unsigned run_off;
    int unsigned run_len;
    bit          fits;
    bit          done;
    cnt  = 32'(req.count);
    hint = 32'(req.base_hint);
    base = hint;
    res.status = STATUS_NO_RUN;

    // A fixed request, or a search with a hint, first tries the run at the hint.
    if (req.fixed_mode || hint != 0) begin
      fits = (hint + cnt <= NUM_VECTORS);
      for (int unsigned k = 0; k < cnt && fits; k++) begin
        if (model_taken[hint + k]) fits = 1'b0;
      end
      if (cnt == 0 || fits) res.status = STATUS_GRANTED;
    end

    // First-fit scan upward from the search start.
    if (res.status == STATUS_NO_RUN && !req.fixed_mode) begin
      if (cnt == 0) begin
        res.status = STATUS_GRANTED;
        base = 32'(model_search_start);
      end else begin
        run_off = 32'(model_search_start);
        run_len = 0;
        done = 1'b0;
        for (int unsigned i = 32'(model_search_start); i < NUM_VECTORS && !done; i++) begin
          if (run_off > BASE_LIMIT) begin
            done = 1'b1;
          end else if (model_taken[i]) begin
            run_len = 0;
            run_off = i + 1;
          end else begin
            run_len++;
            if (run_len >= cnt) begin
              res.status = STATUS_GRANTED;
              base = run_off;
              done = 1'b1;
            end
          end
        end
      end
    end

    if (res.status == STATUS_GRANTED && req.exclusive) begin
      for (int unsigned k = 0; k < cnt; k++) begin
        if (base + k < NUM_VECTORS) model_taken[base + k] = 1'b1;
      end
    end
    res.granted_base = (res.status == STATUS_GRANTED) ? base[7:0] : req.base_hint;
    return res;
  endfunction

  // Random request: mostly small runs, a few large ones, rare oversized counts.
  function automatic alloc_req_t random_request();
    alloc_req_t req;
    int         roll;
    req.fixed_mode = ($urandom_range(0, 2) == 0);
    if (!req.fixed_mode && $urandom_range(0, 1) == 0) req.base_hint = 8'd0;
    else req.base_hint = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < 5)       req.count = 9'd0;
    else if (roll < 80) req.count = 9'($urandom_range(1, 8));
    else if (roll < 95) req.count = 9'($urandom_range(9, 64));
    else if (roll < 99) req.count = 9'($urandom_range(65, 256));
    else                req.count = 9'($urandom_range(257, 511));
    // Keep exclusive grants sparse so the map fills slowly over the run.
    if (req.count <= 8) req.exclusive = ($urandom_range(0, 11) == 0);
    else                req.exclusive = ($urandom_range(0, 63) == 0);
    return req;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offers one request and records its expected result once it is transferred.
  // Entered and left at a falling edge; valid stays high for a back-to-back item.
  task automatic send_request(input alloc_req_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {7'd0, req.base_hint, req.count};
    in_tuser  = {req.exclusive, req.fixed_mode};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_allocs.push_back(allocate_vectors(req));
    @(negedge clk);
  endtask

  task automatic send_alloc(input int cnt, input int hint, input bit fixed, input bit excl);
    alloc_req_t req;
    req.count      = 9'(cnt);
    req.base_hint  = 8'(hint);
    req.fixed_mode = fixed;
    req.exclusive  = excl;
    send_request(req);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (expected_allocs.size() != 0) @(negedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic set_search_start(input logic [7:0] value);
    wait_drained();
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    model_search_start = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver: a long hold when a test asks for one, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else if (steady) begin
      out_tready = 1'b1;
    end else if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 70) begin
        out_tready = 1'b1;
      end else begin
        out_tready = 1'b0;
        stall_left = (rx_roll < 97) ? $urandom_range(0, 3) : $urandom_range(20, 80);
      end
    end
  end

  // Each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    alloc_res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_allocs.size() == 0) begin
        $error("unexpected result: status %0d granted_base %0d", out_tuser, out_tdata);
        mismatch_count++;
      end else begin
        exp_res = expected_allocs.pop_front();
        if (out_tuser !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_tuser);
          mismatch_count++;
        end
        if (out_tdata !== exp_res.granted_base) begin
          $error("granted_base: expected %0d, got %0d", exp_res.granted_base, out_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // Zero counts always succeed and never mark anything.
  task automatic test_zero_count();
    send_alloc(0, 0, 1'b1, 1'b1);
    send_alloc(0, 255, 1'b1, 1'b0);
    send_alloc(0, 0, 1'b0, 1'b1);
    send_alloc(0, 77, 1'b0, 1'b1);
  endtask

  // Runs that touch or pass the top of the table, and oversized counts.
  task automatic test_table_edges();
    send_alloc(256, 0, 1'b1, 1'b0);
    send_alloc(256, 1, 1'b1, 1'b0);
    send_alloc(1, 255, 1'b1, 1'b1);
    send_alloc(2, 255, 1'b1, 1'b0);
    send_alloc(511, 0, 1'b0, 1'b0);
    send_alloc(300, 3, 1'b1, 1'b0);
    send_alloc(224, 0, 1'b0, 1'b0);
    send_alloc(223, 0, 1'b0, 1'b0);
  endtask

  // A blocked hint falls back to the first-fit scan; taken runs are skipped.
  task automatic test_hint_fallback();
    send_alloc(4, 40, 1'b1, 1'b1);
    send_alloc(1, 42, 1'b1, 1'b0);
    send_alloc(2, 42, 1'b0, 1'b1);
    send_alloc(3, 100, 1'b0, 1'b0);
    send_alloc(8, 0, 1'b0, 1'b0);
  endtask

  // The search start register at both ends of its range.
  task automatic test_search_start_extremes();
    set_search_start(8'd255);
    send_alloc(1, 0, 1'b0, 1'b0);
    send_alloc(0, 0, 1'b0, 1'b0);
    set_search_start(8'd0);
    send_alloc(1, 0, 1'b0, 1'b1);
    send_alloc(1, 0, 1'b1, 1'b0);
  endtask

  task automatic test_random_traffic(input logic [7:0] start, input int num_items);
    set_search_start(start);
    repeat (num_items) send_request(random_request());
  endtask

  // The receiver holds off while the sender keeps offering, so input stalls.
  task automatic test_output_backpressure();
    wait_drained();
    steady = 1'b1;
    hold_left = 3000;
    repeat (40) send_request(random_request());
    steady = 1'b0;
  endtask

  // The sender stops until every outstanding result is back, then resumes.
  task automatic test_drained_pause();
    repeat (20) send_request(random_request());
    wait_drained();
    repeat (20) send_request(random_request());
  endtask

  initial begin
    model_taken = '0;
    model_search_start = SEARCH_START_RESET;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_zero_count();
    test_table_edges();
    test_hint_fallback();
    test_search_start_extremes();

    test_random_traffic(8'd0, 370);
    test_random_traffic(8'($urandom_range(1, 254)), 370);
    steady = 1'b1;
    test_random_traffic(8'd255, 400);
    steady = 1'b0;
    test_output_backpressure();
    test_random_traffic(SEARCH_START_RESET, 370);
    test_drained_pause();
    test_random_traffic(8'($urandom_range(100, 220)), 370);

    // Let everything come back, then watch a while for stray results.
    wait_drained();
    repeat (1000) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** vector_block_allocator_unit: PASSED **");
    end else begin
      $display("** vector_block_allocator_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #100ms;
    $display("** vector_block_allocator_unit: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
hdl/vba_pkg.sv
hdl/vba_seq.sv
hdl/vba_dp.sv
hdl/vector_block_allocator_unit.sv
tb/tb.sv
